/* src/abst_pkg.sv */
package abst_pkg;

    // Result codes carried on the output side.
    typedef logic [2:0] status_t;

    localparam status_t STATUS_INSERTED  = 3'd0;
    localparam status_t STATUS_OVERFLOW  = 3'd1;
    localparam status_t STATUS_FOUND     = 3'd2;
    localparam status_t STATUS_NOT_FOUND = 3'd3;
    localparam status_t STATUS_DUPLICATE = 3'd4;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned SLOT_W = 6;

    // A store entry holds the used flag above the key.
    localparam int unsigned ENTRY_W = KEY_W + 1;

    // Request kinds on the input side.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        WALK_CLEAR,
        WALK_IDLE,
        WALK_STEP
    } walk_state_t;

    // Finished result handed from the walker to the output register.
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } result_t;

endpackage

/* src/array_bst_insert_search.sv */
// Each accepted word walks the tree one level per step, at most 6 levels with 63 slots;
// one walk at a time, with an idle state between walks. An output stall holds the
// finished walk until the output register can take its word.
// The walk is bounded by the single registered read port of the key store.
// Reset is asynchronous and active low; afterwards a clearing pass marks every slot unused,
// and no word is accepted until it ends.
module array_bst_insert_search #(
    parameter int unsigned NODES = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] slot, [7:6] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    import abst_pkg::*;

    localparam int unsigned IW = $clog2(NODES);

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    result_t              res;
    logic                 out_free;

    logic              m_tvalid_reg;
    status_t           status_reg;
    logic [SLOT_W-1:0] slot_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // Key store: used flag and key per slot.
    abst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    abst_walk #(
        .NODES (NODES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser[0]),
        .in_key    ($signed(s_tdata)),
        .out_free  (out_free),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: the finished word waits here while the next walk starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= res.status;
            slot_reg   <= res.slot;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, slot_reg};

endmodule

/* src/abst_ram.sv */
module abst_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/abst_walk.sv */
module abst_walk #(
    parameter int unsigned NODES = 63
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               in_mode,
    input  logic signed [abst_pkg::KEY_W-1:0]  in_key,
    input  logic                               out_free,
    output abst_pkg::result_t                  res,
    output logic                               ram_we,
    output logic [$clog2(NODES)-1:0]           ram_waddr,
    output logic [abst_pkg::ENTRY_W-1:0]       ram_wdata,
    output logic [$clog2(NODES)-1:0]           ram_raddr,
    input  logic [abst_pkg::ENTRY_W-1:0]       ram_rdata
);

    import abst_pkg::*;

    localparam int unsigned IW = $clog2(NODES);

    localparam logic [IW+1:0] NODES_W = (IW+2)'(NODES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

    walk_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          mode_reg;
    logic signed [KEY_W-1:0] key_reg;

    logic                    rd_used;
    logic signed [KEY_W-1:0] rd_key;
    logic [IW+1:0]           child_idx;
    logic [IW+SLOT_W:0]      idx_wide;
    logic                    accept;

    assign rd_used  = ram_rdata[ENTRY_W-1];
    assign rd_key   = $signed(ram_rdata[KEY_W-1:0]);
    assign accept   = in_valid && in_ready;
    assign idx_wide = (IW+SLOT_W+1)'(idx_reg);

    // Left child for a smaller key, right child for a larger one. The extra top bit keeps
    // the right child of the last slot from wrapping when the store size is a power of two.
    assign child_idx = {1'b0, idx_reg, 1'b0}
                     + ((key_reg < rd_key) ? (IW+2)'(1) : (IW+2)'(2));

    // State and index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WALK_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // The request is held for the length of its walk.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
        end
    end

    // Walk sequencer: one tree level per cycle, each level's store read issued in the state before it.
    always_comb
    begin
        logic    done;
        status_t status;
        logic [SLOT_W-1:0] slot;

        state_next = state_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = {1'b1, key_reg};
        ram_raddr  = idx_reg;
        res        = '0;
        done       = 1'b0;
        status     = STATUS_NOT_FOUND;
        slot       = '0;

        unique case (state_reg)
            WALK_CLEAR:
            begin
                // Clearing pass: mark every slot unused.
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = WALK_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            WALK_IDLE:
            begin
                in_ready  = 1'b1;
                ram_raddr = '0;
                if (in_valid)
                begin
                    idx_next   = '0;
                    state_next = WALK_STEP;
                end
            end

            WALK_STEP:
            begin
                if (!rd_used)
                begin
                    done = 1'b1;
                    if (mode_reg == MODE_SEARCH)
                    begin
                        status = STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        status = STATUS_INSERTED;
                        slot   = idx_wide[SLOT_W-1:0];
                    end
                end
                else if (rd_key == key_reg)
                begin
                    done   = 1'b1;
                    status = (mode_reg == MODE_SEARCH) ? STATUS_FOUND : STATUS_DUPLICATE;
                    slot   = idx_wide[SLOT_W-1:0];
                end
                else if (child_idx >= NODES_W)
                begin
                    done   = 1'b1;
                    status = (mode_reg == MODE_SEARCH) ? STATUS_NOT_FOUND : STATUS_OVERFLOW;
                end

                if (done)
                begin
                    // Hold on the same entry until the output register can take the word.
                    if (out_free)
                    begin
                        res.valid  = 1'b1;
                        res.status = status;
                        res.slot   = slot;
                        ram_we     = (mode_reg == MODE_INSERT) && !rd_used;
                        state_next = WALK_IDLE;
                    end
                end
                else
                begin
                    idx_next  = child_idx[IW-1:0];
                    ram_raddr = child_idx[IW-1:0];
                end
            end

            default:
            begin
                state_next = WALK_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

endmodule
